>>> hw/rtl/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

  localparam int unsigned RESULT_FIFO_DEPTH = 8;
  localparam int unsigned MAX_RESULTS       = 3;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       decode_error;
  } res_t;

  // results caused by one item, slot 0 first
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       slot;
  } burst_t;

  typedef struct packed {
    logic valid;
    logic [5:0] sextet;
  } sextet_t;

  function automatic sextet_t map_sextet(input logic [7:0] c);
    sextet_t r;
    r.valid  = 1'b1;
    r.sextet = 6'd0;
    case (c) inside
      [8'h41:8'h5A]: r.sextet = 6'(c - 8'h41);
      [8'h61:8'h7A]: r.sextet = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.sextet = 6'(c - 8'h30 + 8'd52);
      8'h2B:         r.sextet = 6'd62;
      8'h2F:         r.sextet = 6'd63;
      default:       r.valid  = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/b64d_group.sv
`default_nettype none
module b64d_group
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       go,
  input  wire logic [7:0] item_char,
  input  wire logic       item_final,
  output burst_t          burst
);

  logic [5:0] store_r [3];
  logic [5:0] store_nxt [3];
  logic [1:0] pos_r, pos_nxt;
  logic [2:0] pad_r, pad_nxt;
  logic       bad_r, bad_nxt;
  logic       discard_r, discard_nxt;

  sextet_t    m;
  logic       is_pad;
  logic [5:0] s [4];
  logic [3:0] pad;
  logic [7:0] b1, b2, b3;
  logic       bad;

  always_comb begin
    m      = map_sextet(item_char);
    is_pad = (item_char == PAD_CHAR);

    // assemble the four positions of a group that ends on this item
    for (int i = 0; i < 4; i++) begin
      if (i < 32'(pos_r)) begin
        s[i]   = (i < 3) ? store_r[i % 3] : 6'd0;
        pad[i] = (i < 3) ? pad_r[i % 3] : 1'b1;
      end else if (i == 32'(pos_r)) begin
        s[i]   = m.sextet;
        pad[i] = is_pad;
      end else begin
        s[i]   = 6'd0;
        pad[i] = 1'b1;
      end
    end
    b1  = {s[0], s[1][5:4]};
    b2  = {s[1][3:0], s[2][5:2]};
    b3  = {s[2][1:0], s[3]};
    bad = bad_r || (!m.valid && !is_pad);

    store_nxt   = store_r;
    pos_nxt     = pos_r;
    pad_nxt     = pad_r;
    bad_nxt     = bad_r;
    discard_nxt = discard_r;
    burst       = '0;

    if (go) begin
      if (discard_r) begin
        if (item_final) begin
          discard_nxt = 1'b0;
          store_nxt   = '{default: 6'd0};
          pos_nxt     = 2'd0;
          pad_nxt     = 3'd0;
          bad_nxt     = 1'b0;
        end
      end else if (!item_final && pos_r != 2'd3) begin
        store_nxt[pos_r] = m.sextet;
        if (is_pad) begin
          pad_nxt[pos_r] = 1'b1;
        end else if (!m.valid) begin
          bad_nxt = 1'b1;
        end
        pos_nxt = pos_r + 2'd1;
      end else begin
        store_nxt = '{default: 6'd0};
        pos_nxt   = 2'd0;
        pad_nxt   = 3'd0;
        bad_nxt   = 1'b0;
        if (bad || (!item_final && (|pad))) begin
          discard_nxt   = !item_final;
          burst.cnt     = 2'd1;
          burst.slot[0] = '{out_byte: 8'd0, run_last: 1'b1, stream_end: 1'b1,
                            decode_error: 1'b1};
        end else if (!item_final) begin
          burst.cnt     = 2'd3;
          burst.slot[0] = '{out_byte: b1, run_last: 1'b0, stream_end: 1'b0,
                            decode_error: 1'b0};
          burst.slot[1] = '{out_byte: b2, run_last: 1'b0, stream_end: 1'b0,
                            decode_error: 1'b0};
          burst.slot[2] = '{out_byte: b3, run_last: 1'b1, stream_end: 1'b0,
                            decode_error: 1'b0};
        end else begin
          // final group: byte two only if position three is data, likewise byte three
          burst.cnt     = 2'd1 + 2'(!pad[2]) + 2'(!pad[3]);
          burst.slot[0] = '{out_byte: b1, run_last: (pad[2] && pad[3]), stream_end: 1'b1,
                            decode_error: 1'b0};
          burst.slot[1] = '{out_byte: (!pad[2] ? b2 : b3), run_last: (pad[2] || pad[3]),
                            stream_end: 1'b1, decode_error: 1'b0};
          burst.slot[2] = '{out_byte: b3, run_last: 1'b1, stream_end: 1'b1,
                            decode_error: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r   <= '{default: 6'd0};
      pos_r     <= 2'd0;
      pad_r     <= 3'd0;
      bad_r     <= 1'b0;
      discard_r <= 1'b0;
    end else begin
      store_r   <= store_nxt;
      pos_r     <= pos_nxt;
      pad_r     <= pad_nxt;
      bad_r     <= bad_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/b64d_fifo.sv
`default_nettype none
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = RESULT_FIFO_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire burst_t burst,
  output logic        space_ok,
  output logic        out_valid,
  input  wire logic   out_stall,
  output res_t        head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_idx [MAX_RESULTS];
  logic [PW:0]   sum [MAX_RESULTS];
  logic          pop;

  function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
    logic [PW:0] r;
    r = v;
    if (r >= (PW+1)'(DEPTH)) begin
      r = r - (PW+1)'(DEPTH);
    end
    return r[PW-1:0];
  endfunction

  always_comb begin
    for (int k = 0; k < int'(MAX_RESULTS); k++) begin
      sum[k]    = {1'b0, wr_ptr_r} + (PW+1)'(k);
      wr_idx[k] = wrap(sum[k]);
    end
    out_valid  = (count_r != '0);
    pop        = out_valid && !out_stall;
    head       = mem_r[rd_ptr_r];
    // room for a worst-case burst, judged before this cycle's pop
    space_ok   = (count_r <= CW'(DEPTH - MAX_RESULTS));
    wr_ptr_nxt = wrap({1'b0, wr_ptr_r} + (PW+1)'(burst.cnt));
    rd_ptr_nxt = pop ? wrap({1'b0, rd_ptr_r} + (PW+1)'(1)) : rd_ptr_r;
    count_nxt  = count_r + CW'(burst.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < int'(MAX_RESULTS); k++) begin
      if (2'(k) < burst.cnt) begin
        mem_r[wr_idx[k]] <= burst.slot[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/base64_stream_decoder_core.sv
// Base64 stream decoder, decode side only.
// Input channel: in_valid / in_stall carry one character per item with
// in_final_char marking the last character of an encoded stream.
// Result channel: out_valid / out_stall carry one decoded byte per item with
// run_last, stream_end and decode_error flags. An item moves on an edge where
// valid is high and stall is low.
// The results of a character reach out_* through the input register and the
// result queue, in order, one result per cycle while out_stall is low.
// Throughput: one character per cycle; a group of four yields at most three
// results, which a result queue of FIFO_DEPTH entries smooths out. The input
// stalls while a character waits in the input register and the queue holds
// more than FIFO_DEPTH - 3 results.
// Reset (rst_n low, synchronous) empties the queue and the input register and
// starts a fresh stream at group position one.
// When the receiver stalls, the current result holds and the queue fills; the
// input then stalls once the queue can no longer take a full group's results.
`default_nettype none
module base64_stream_decoder_core
  import b64d_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = RESULT_FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_final_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_stream_end,
  output logic            out_decode_error
);

  logic       item_valid_r, item_valid_nxt;
  logic [7:0] item_char_r;
  logic       item_final_r;
  logic       space_ok;
  logic       go;
  logic       accept;
  burst_t     burst;
  res_t       head;

  always_comb begin
    go             = item_valid_r && space_ok;
    in_stall       = item_valid_r && !space_ok;
    accept         = in_valid && !in_stall;
    item_valid_nxt = accept ? 1'b1 : (go ? 1'b0 : item_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_char_r  <= in_char;
      item_final_r <= in_final_char;
    end
  end

  b64d_group u_group (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .item_char  (item_char_r),
    .item_final (item_final_r),
    .burst      (burst)
  );

  b64d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst     (burst),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte         = head.out_byte;
  assign out_run_last     = head.run_last;
  assign out_stream_end   = head.stream_end;
  assign out_decode_error = head.decode_error;

endmodule
`default_nettype wire
